// ----- src/gcpk_pkg.sv -----
// Package of the Gaussian-damped charge pair kernel.
// Holds widths, the erf table, the pipeline types and the square-root step.
// No dependencies.
`default_nettype none
package gcpk_pkg;

	localparam int NumTypes  = 4;
	localparam int RegCount  = 8;
	localparam int CfgIdxW   = $clog2(RegCount);
	localparam int CfgW      = 24;
	localparam int SqrtSteps = 32;
	localparam int Div1Steps = 18;
	localparam int Div2Steps = 33;

	localparam logic [CfgIdxW-1:0] RegHardBase = 3'd4;
	localparam logic [5:0]         ErfLast     = 6'd31;
	localparam logic [16:0]        ErfOne      = 17'd65536;

	localparam logic [16:0] ERF_TABLE [32] = '{
		17'd0,     17'd7370,  17'd14595, 17'd21537, 17'd28075, 17'd34111, 17'd39574,
		17'd44420, 17'd48634, 17'd52226, 17'd55227, 17'd57685, 17'd59658, 17'd61211,
		17'd62409, 17'd63315, 17'd63986, 17'd64474, 17'd64821, 17'd65063, 17'd65229,
		17'd65341, 17'd65414, 17'd65461, 17'd65491, 17'd65509, 17'd65521, 17'd65527,
		17'd65531, 17'd65533, 17'd65535, 17'd65536
	};

	typedef struct packed {
		logic [23:0] pidx;
		logic        diag;
		logic        coinc;
		logic [23:0] hard;
	} side_t;

	typedef struct packed {
		logic [63:0] v;
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// One result bit of an integer square root, radicand bits taken from the top.
	function automatic sqrt_t sqrt_step(input sqrt_t a);
		logic [33:0] sh;
		logic [33:0] trial;
		sqrt_t       r;
		sh    = {a.rem[31:0], a.v[63:62]};
		trial = {a.root, 2'b01};
		r.v   = {a.v[61:0], 2'b00};
		if (sh >= trial) begin
			r.rem  = sh - trial;
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem  = sh;
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/gaussian_charge_pair_kernel.sv -----
// Top level of the Gaussian-damped charge pair kernel.
// A fully pipelined datapath; depends on gcpk_pkg.
//
// Usage: each input item on the s_axis channel names one matrix element (row, col),
// the two atom positions and the two atom types; one result item per input leaves
// on the m_axis channel carrying the element value, its packed lower-triangle index
// and a status bit that flags coincident atoms on an off-diagonal element.
// The radii and hardness per atom type are set through the cfg write port; the user
// must write them only while no item is in flight, the block has no check for it.
// Off-diagonal elements are erf(d / w) / d in fixed point.
// Throughput is one item per cycle when m_axis does not stall: every stage of the two
// square roots (one bit per stage, 32 stages) and of the two restoring divisions (one
// quotient bit per stage, 18 and 33 stages) is its own register stage.
// Reset clears all valid bits and loads the radii with 1.0 and hardness with 0.
// When the receiver stalls the whole pipeline holds and s_axis_tready drops; no item
// is lost or repeated, and the pipeline restarts as soon as the result is taken.
`default_nettype none
module gaussian_charge_pair_kernel (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gcpk_pkg::CfgIdxW-1:0]  cfg_idx,
	input  wire logic [gcpk_pkg::CfgW-1:0]     cfg_wdata,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// row, col, pos_x_a, pos_y_a, pos_z_a, pos_x_b, pos_y_b, pos_z_b
	input  wire logic [215:0]                  s_axis_tdata,
	// kind_a, kind_b
	input  wire logic [3:0]                    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// element_value, tri_index
	output logic [55:0]                        m_axis_tdata,
	// status
	output logic [0:0]                         m_axis_tuser
);
	import gcpk_pkg::*;

	typedef struct packed {
		sqrt_t d;
		sqrt_t w;
		logic  shft;
		side_t side;
	} rt_t;

	typedef struct packed {
		logic [32:0] d;
		logic [24:0] w;
		logic [25:0] rem;
		logic [17:0] q;
		logic        sat;
		side_t       side;
	} d1_t;

	typedef struct packed {
		logic [32:0] d;
		logic [16:0] e;
		logic [32:0] rem;
		logic [32:0] q;
		side_t       side;
	} d2_t;

	logic [CfgW-1:0] radius_q   [NumTypes];
	logic [CfgW-1:0] hardness_q [NumTypes];

	logic adv;

	logic [11:0] row_in, col_in, hi, lo;
	logic [31:0] pos_in [6];
	logic [1:0]  kind_a, kind_b;
	logic [24:0] tri_prod;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] ax_s1, ay_s1, az_s1;
	logic [23:0] ri_s1, rj_s1;
	side_t       side_s1, side_s2, side_s3;
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic [47:0] ri2_s2, rj2_s2;
	logic [65:0] sum_s3;
	logic [48:0] wsum_s3;

	rt_t         rt_s   [SqrtSteps+1];
	logic        rt_v   [SqrtSteps+1];
	d1_t         d1_s   [Div1Steps+1];
	logic        d1_v   [Div1Steps+1];
	logic [21:0] t_ea;
	logic [16:0] base_sa, step_sa;
	logic [15:0] f_sa;
	logic        esat_sa, v_sa;
	logic [32:0] d_sa;
	side_t       side_sa;
	logic [28:0] interp;
	d2_t         d2_s   [Div2Steps+1];
	logic        d2_v   [Div2Steps+1];

	logic        m_vld_q;
	logic [31:0] val_q;
	logic [23:0] pidx_q;
	logic        stat_q;

	function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] df;
		df = {a[31], a} - {b[31], b};
		return df[32] ? 32'(-df) : df[31:0];
	endfunction

	assign adv           = ~m_vld_q | m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumTypes; i++) begin
				radius_q[i]   <= 24'd65536;
				hardness_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_idx < RegHardBase) radius_q[cfg_idx[1:0]] <= cfg_wdata;
			else hardness_q[cfg_idx[1:0]] <= cfg_wdata;
		end
	end

	always_comb begin
		row_in = s_axis_tdata[11:0];
		col_in = s_axis_tdata[23:12];
		for (int i = 0; i < 6; i++) pos_in[i] = s_axis_tdata[24+32*i +: 32];
		kind_a = s_axis_tuser[1:0];
		kind_b = s_axis_tuser[3:2];
		hi = (col_in > row_in) ? col_in : row_in;
		lo = (col_in > row_in) ? row_in : col_in;
		tri_prod = 25'(hi) * (25'(hi) + 25'd1);
	end

	// Stages 1 to 4: differences, squares, sums, radicand scaling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1         <= abs_diff(pos_in[0], pos_in[3]);
			ay_s1         <= abs_diff(pos_in[1], pos_in[4]);
			az_s1         <= abs_diff(pos_in[2], pos_in[5]);
			ri_s1         <= radius_q[kind_a];
			rj_s1         <= radius_q[kind_b];
			side_s1.pidx  <= tri_prod[24:1] + 24'(lo);
			side_s1.diag  <= (row_in == col_in);
			side_s1.coinc <= 1'b0;
			side_s1.hard  <= hardness_q[kind_a];

			sx_s2         <= 64'(ax_s1) * 64'(ax_s1);
			sy_s2         <= 64'(ay_s1) * 64'(ay_s1);
			sz_s2         <= 64'(az_s1) * 64'(az_s1);
			ri2_s2        <= 48'(ri_s1) * 48'(ri_s1);
			rj2_s2        <= 48'(rj_s1) * 48'(rj_s1);
			side_s2.pidx  <= side_s1.pidx;
			side_s2.diag  <= side_s1.diag;
			side_s2.hard  <= side_s1.hard;
			side_s2.coinc <= (ax_s1 == '0) && (ay_s1 == '0) && (az_s1 == '0);

			sum_s3        <= 66'(sx_s2) + 66'(sy_s2) + 66'(sz_s2);
			wsum_s3       <= 49'(ri2_s2) + 49'(rj2_s2);
			side_s3       <= side_s2;

			rt_s[0].shft  <= (sum_s3[65:64] != 2'b00);
			rt_s[0].d.v   <= (sum_s3[65:64] != 2'b00) ? sum_s3[65:2] : sum_s3[63:0];
			rt_s[0].d.rem <= '0;
			rt_s[0].d.root <= '0;
			rt_s[0].w.v   <= 64'(wsum_s3);
			rt_s[0].w.rem <= '0;
			rt_s[0].w.root <= '0;
			rt_s[0].side  <= side_s3;
		end
	end

	assign rt_v[0] = v_s4;

	// Square roots of the distance and of the combined width, one bit per stage.
	for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v[j+1] <= 1'b0;
			else if (adv) rt_v[j+1] <= rt_v[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_s[j+1].d    <= sqrt_step(rt_s[j].d);
				rt_s[j+1].w    <= sqrt_step(rt_s[j].w);
				rt_s[j+1].shft <= rt_s[j].shft;
				rt_s[j+1].side <= rt_s[j].side;
			end
		end
	end

	// Division d / w set up: quotients of 2^18 or more saturate erf.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d1_v[0] <= 1'b0;
		else if (adv) d1_v[0] <= rt_v[SqrtSteps];
	end

	always_ff @(posedge clk) begin
		logic [32:0] dd;
		logic [24:0] ww;
		if (adv) begin
			dd = rt_s[SqrtSteps].shft ? {rt_s[SqrtSteps].d.root, 1'b0}
			                          : {1'b0, rt_s[SqrtSteps].d.root};
			ww = rt_s[SqrtSteps].w.root[24:0];
			d1_s[0].d    <= dd;
			d1_s[0].w    <= ww;
			d1_s[0].rem  <= dd[27:2];
			d1_s[0].q    <= '0;
			d1_s[0].sat  <= (ww == '0) || (dd >= {6'b0, ww, 2'b00});
			d1_s[0].side <= rt_s[SqrtSteps].side;
		end
	end

	for (genvar j = 0; j < Div1Steps; j++) begin : g_div1
		logic        nb;
		logic [25:0] sh;
		logic        ge;
		if (j == 0) begin : g_b1
			assign nb = d1_s[j].d[1];
		end else if (j == 1) begin : g_b0
			assign nb = d1_s[j].d[0];
		end else begin : g_bz
			assign nb = 1'b0;
		end
		assign sh = {d1_s[j].rem[24:0], nb};
		assign ge = (sh >= {1'b0, d1_s[j].w});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d1_v[j+1] <= 1'b0;
			else if (adv) d1_v[j+1] <= d1_v[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d1_s[j+1].d    <= d1_s[j].d;
				d1_s[j+1].w    <= d1_s[j].w;
				d1_s[j+1].sat  <= d1_s[j].sat;
				d1_s[j+1].side <= d1_s[j].side;
				d1_s[j+1].rem  <= ge ? (sh - {1'b0, d1_s[j].w}) : sh;
				d1_s[j+1].q    <= {d1_s[j].q[16:0], ge};
			end
		end
	end

	// erf by table lookup and linear interpolation.
	assign t_ea   = 22'(d1_s[Div1Steps].q) * 22'd10;
	assign interp = 29'(step_sa) * 29'(f_sa);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa    <= 1'b0;
			d2_v[0] <= 1'b0;
		end else if (adv) begin
			v_sa    <= d1_v[Div1Steps];
			d2_v[0] <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			esat_sa      <= d1_s[Div1Steps].sat || (t_ea[21:16] >= ErfLast);
			base_sa      <= ERF_TABLE[t_ea[20:16]];
			step_sa      <= ERF_TABLE[t_ea[20:16] + 5'd1] - ERF_TABLE[t_ea[20:16]];
			f_sa         <= t_ea[15:0];
			d_sa         <= d1_s[Div1Steps].d;
			side_sa      <= d1_s[Div1Steps].side;

			d2_s[0].e    <= esat_sa ? ErfOne : base_sa + 17'(interp[28:16]);
			d2_s[0].d    <= d_sa;
			d2_s[0].rem  <= '0;
			d2_s[0].q    <= '0;
			d2_s[0].side <= side_sa;
		end
	end

	// Division (e * 2^16) / d, one quotient bit per stage.
	for (genvar j = 0; j < Div2Steps; j++) begin : g_div2
		logic        nb;
		logic [33:0] sh;
		logic        ge;
		if (Div2Steps - 1 - j >= 16) begin : g_num
			assign nb = d2_s[j].e[Div2Steps - 1 - j - 16];
		end else begin : g_zero
			assign nb = 1'b0;
		end
		assign sh = {d2_s[j].rem, nb};
		assign ge = (sh >= {1'b0, d2_s[j].d});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d2_v[j+1] <= 1'b0;
			else if (adv) d2_v[j+1] <= d2_v[j];
		end
		always_ff @(posedge clk) begin
			logic [33:0] nr;
			if (adv) begin
				nr = ge ? (sh - {1'b0, d2_s[j].d}) : sh;
				d2_s[j+1].d    <= d2_s[j].d;
				d2_s[j+1].e    <= d2_s[j].e;
				d2_s[j+1].side <= d2_s[j].side;
				d2_s[j+1].rem  <= nr[32:0];
				d2_s[j+1].q    <= {d2_s[j].q[31:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_vld_q <= 1'b0;
		else if (adv) m_vld_q <= d2_v[Div2Steps];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pidx_q <= d2_s[Div2Steps].side.pidx;
			stat_q <= ~d2_s[Div2Steps].side.diag & d2_s[Div2Steps].side.coinc;
			if (d2_s[Div2Steps].side.diag) val_q <= 32'(d2_s[Div2Steps].side.hard);
			else if (d2_s[Div2Steps].side.coinc) val_q <= '0;
			else if (d2_s[Div2Steps].q[32]) val_q <= '1;
			else val_q <= d2_s[Div2Steps].q[31:0];
		end
	end

	assign m_axis_tvalid   = m_vld_q;
	assign m_axis_tdata    = {pidx_q, val_q};
	assign m_axis_tuser[0] = stat_q;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench of the Gaussian-damped charge pair kernel.
// Drives element items with random gaps, predicts each element value in fixed
// point and checks the results in order; depends on gcpk_pkg and the kernel.
`timescale 1ns / 100ps
module testbench;

	import gcpk_pkg::*;

	localparam int LatencyCycles = 91;

	localparam logic [16:0] ErfTab [32] = '{
		17'd0,     17'd7370,  17'd14595, 17'd21537, 17'd28075, 17'd34111, 17'd39574,
		17'd44420, 17'd48634, 17'd52226, 17'd55227, 17'd57685, 17'd59658, 17'd61211,
		17'd62409, 17'd63315, 17'd63986, 17'd64474, 17'd64821, 17'd65063, 17'd65229,
		17'd65341, 17'd65414, 17'd65461, 17'd65491, 17'd65509, 17'd65521, 17'd65527,
		17'd65531, 17'd65533, 17'd65535, 17'd65536
	};

	typedef enum logic [2:0] {
		REG_RADIUS0 = 3'd0, REG_RADIUS1 = 3'd1, REG_RADIUS2 = 3'd2, REG_RADIUS3 = 3'd3,
		REG_HARD0 = 3'd4, REG_HARD1 = 3'd5, REG_HARD2 = 3'd6, REG_HARD3 = 3'd7
	} reg_idx_e;

	typedef struct packed {
		logic [1:0]  kind_b;
		logic [1:0]  kind_a;
		logic [31:0] zb;
		logic [31:0] yb;
		logic [31:0] xb;
		logic [31:0] za;
		logic [31:0] ya;
		logic [31:0] xa;
		logic [11:0] col;
		logic [11:0] row;
	} pair_t;

	typedef struct packed {
		logic [31:0] value;
		logic [23:0] pidx;
		logic        status;
	} element_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [CfgW-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [215:0] s_axis_tdata = '0;
	logic [3:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	gaussian_charge_pair_kernel i_dut (.*);

	always #5 clk = ~clk;

	logic [23:0] radius [4];
	logic [23:0] hardness [4];
	pair_t pending_pairs [$];
	element_t expected_elements [$];
	int mismatches = 0;
	bit hold_sender = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic logic [63:0] int_sqrt(input logic [65:0] v);
		logic [67:0] rem;
		logic [33:0] root;
		rem  = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
			if (rem >= {root, 2'b01}) begin
				rem  = rem - {root, 2'b01};
				root = {root[32:0], 1'b1};
			end else begin
				root = {root[32:0], 1'b0};
			end
		end
		return 64'(root);
	endfunction

	function automatic logic [31:0] abs_delta(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		return d < 0 ? 32'(-d) : 32'(d);
	endfunction

	function automatic element_t predict_element(input pair_t p);
		element_t r;
		logic [11:0] hi, lo;
		logic [1:0] ka, kb;
		logic [31:0] ax, ay, az;
		logic [65:0] s;
		logic [63:0] d, w, t, k, e, q;
		logic [47:0] ri, rj;
		hi = p.row > p.col ? p.row : p.col;
		lo = p.row > p.col ? p.col : p.row;
		ka = p.kind_a;
		kb = p.kind_b;
		r.pidx = 24'((64'(hi) * (64'(hi) + 1)) / 2 + lo);
		r.status = 1'b0;
		r.value = '0;
		if (hi == lo) begin
			r.value = 32'(hardness[ka]);
		end else begin
			ax = abs_delta(p.xa, p.xb);
			ay = abs_delta(p.ya, p.yb);
			az = abs_delta(p.za, p.zb);
			if (ax == 0 && ay == 0 && az == 0) begin
				r.status = 1'b1;
			end else begin
				s = 66'(ax) * ax + 66'(ay) * ay + 66'(az) * az;
				d = s[65:64] == 0 ? int_sqrt(s) : int_sqrt(s >> 2) << 1;
				ri = 48'(radius[ka]);
				rj = 48'(radius[kb]);
				w = int_sqrt(66'(ri * ri) + 66'(rj * rj));
				if (w == 0) begin
					e = 65536;
				end else begin
					t = ((d << 16) / w) * 10;
					k = t >> 16;
					if (k >= 31) e = 65536;
					else e = ErfTab[k[4:0]] + (((ErfTab[k[4:0] + 5'd1] - ErfTab[k[4:0]])
						* t[15:0]) >> 16);
				end
				q = (e << 16) / d;
				r.value = q > 64'hFFFFFFFF ? 32'hFFFFFFFF : q[31:0];
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_elements.push_back(predict_element(pending_pairs.pop_front()));
			send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
		end else if (!s_axis_tvalid && send_gap > 0) begin
			send_gap--;
		end
		if ((!s_axis_tvalid || s_axis_tready) && arst_n) begin
			if (pending_pairs.size() > 0 && send_gap == 0 && !hold_sender) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_pairs[0][215:0];
				s_axis_tuser  <= pending_pairs[0][219:216];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("Mismatch in %s: got %h, predicted %h", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_elements.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
			end else begin
				element_t x;
				x = expected_elements.pop_front();
				if (m_axis_tdata[31:0] !== x.value)
					report_mismatch("element_value", m_axis_tdata[31:0], x.value);
				if (m_axis_tdata[55:32] !== x.pidx)
					report_mismatch("tri_index", 32'(m_axis_tdata[55:32]), 32'(x.pidx));
				if (m_axis_tuser[0] !== x.status)
					report_mismatch("status", 32'(m_axis_tuser[0]), 32'(x.status));
			end
		end
		if (m_axis_tvalid && m_axis_tready || !m_axis_tvalid && !m_axis_tready) begin
			recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
		end
		if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n;
		end
	end

	task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		if (idx < REG_HARD0) radius[idx[1:0]] = val;
		else hardness[idx[1:0]] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (pending_pairs.size() > 0 || s_axis_tvalid || expected_elements.size() > 0)
			@(posedge clk);
		repeat (LatencyCycles + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
			2: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
			default: return $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
		endcase
	endfunction

	function automatic pair_t rand_pair;
		pair_t p;
		int mode;
		mode = $urandom_range(0, 9);
		mode = mode < 5 ? 3 : mode < 8 ? 1 : mode == 8 ? 0 : 2;
		p.row = 12'($urandom());
		p.col = $urandom_range(0, 9) == 0 ? 12'($urandom()) : 12'($urandom_range(0, p.row));
		if ($urandom_range(0, 19) == 0) p.col = p.row;
		p.xa = rand_coord(mode);
		p.ya = rand_coord(mode);
		p.za = rand_coord(mode);
		p.xb = rand_coord(mode);
		p.yb = rand_coord(mode);
		p.zb = rand_coord(mode);
		if ($urandom_range(0, 19) == 0) begin
			p.xb = p.xa; p.yb = p.ya; p.zb = p.za;
		end else if ($urandom_range(0, 9) == 0) begin
			p.xb = p.xa + $urandom_range(0, 3) - 1; p.yb = p.ya; p.zb = p.za;
		end
		p.kind_a = 2'($urandom());
		p.kind_b = 2'($urandom());
		return p;
	endfunction

	function automatic pair_t mk_pair(input logic [11:0] r, input logic [11:0] c,
			input logic [31:0] xa, input logic [31:0] xb, input logic [1:0] ka,
			input logic [1:0] kb);
		pair_t p;
		p = '0;
		p.row = r; p.col = c; p.xa = xa; p.xb = xb; p.kind_a = ka; p.kind_b = kb;
		p.ya = 32'h00010000; p.yb = 32'h00010000;
		return p;
	endfunction

	initial begin
		for (int i = 0; i < 4; i++) begin
			radius[i]   = 24'd65536;
			hardness[i] = 24'd0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset values first, then the extremes of the fields.
		pending_pairs.push_back(mk_pair(12'd5, 12'd5, 32'd0, 32'd0, 2'd0, 2'd0));
		pending_pairs.push_back(mk_pair(12'd1, 12'd0, 32'h00010000, 32'd0, 2'd0, 2'd1));
		drain();
		write_reg(REG_RADIUS0, 24'd1);
		write_reg(REG_RADIUS1, 24'hFFFFFF);
		write_reg(REG_RADIUS2, 24'd0);
		write_reg(REG_RADIUS3, 24'd0);
		write_reg(REG_HARD0, 24'd0);
		write_reg(REG_HARD1, 24'hFFFFFF);
		write_reg(REG_HARD2, 24'h012345);
		write_reg(REG_HARD3, 24'h00ABCD);
		for (int k = 0; k < 4; k++)
			pending_pairs.push_back(mk_pair(12'd4095, 12'd4095, $urandom(), 32'd0, 2'(k),
				2'd0));
		pending_pairs.push_back(mk_pair(12'd4095, 12'd0, 32'h80000000, 32'h7FFFFFFF, 2'd0,
			2'd1));
		pending_pairs.push_back(mk_pair(12'd0, 12'd4095, 32'h7FFFFFFF, 32'h80000000, 2'd1,
			2'd1));
		pending_pairs.push_back(mk_pair(12'd3, 12'd1, 32'h1234, 32'h1234, 2'd0, 2'd2));
		pending_pairs.push_back(mk_pair(12'd3, 12'd1, 32'h1235, 32'h1234, 2'd2, 2'd3));
		pending_pairs.push_back(mk_pair(12'd9, 12'd2, 32'h00020000, 32'd0, 2'd2, 2'd2));
		pending_pairs.push_back(mk_pair(12'd9, 12'd2, 32'h00020000, 32'd0, 2'd0, 2'd0));
		pending_pairs.push_back(mk_pair(12'd9, 12'd2, 32'h00000001, 32'd0, 2'd0, 2'd0));
		begin
			pair_t p;
			p = mk_pair(12'd4000, 12'd17, 32'h80000000, 32'h7FFFFFFF, 2'd1, 2'd0);
			p.ya = 32'h80000000; p.yb = 32'h7FFFFFFF; p.za = 32'h7FFFFFFF; p.zb = 32'h80000000;
			pending_pairs.push_back(p);
		end
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			for (int i = 0; i < 8; i++) begin
				logic [23:0] v;
				case ($urandom_range(0, 3))
					0: v = 24'd1;
					1: v = 24'hFFFFFF;
					2: v = 24'($urandom_range(24'h4000, 24'h40000));
					default: v = 24'($urandom());
				endcase
				if (i < 4 && phase == 0) v = 24'd65536;
				write_reg(reg_idx_e'(i), v);
			end
			for (int n = 0; n < 260; n++) pending_pairs.push_back(rand_pair());
			if (phase == 2) begin
				while (pending_pairs.size() > 130) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_elements.size() > 0 || s_axis_tvalid) @(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- gaussian_charge_pair_kernel.f -----
src/gcpk_pkg.sv
src/gaussian_charge_pair_kernel.sv
dv/testbench.sv
